// ===== rtl/scatter_gather_chunker_assert.svh =====
// Assertion macros shared by the walker RTL.
// Each macro expects clk and rst_n in scope.
`ifndef SCATTER_GATHER_CHUNKER_ASSERT_SVH
`define SCATTER_GATHER_CHUNKER_ASSERT_SVH

// Same-cycle implication
`define SGC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SGC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sgc_pkg.sv =====
package sgc_pkg;

    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 24;
    localparam int KIND_W      = 3;
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS);

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CONSUME = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] segment_base;
        logic [LEN_W-1:0]  segment_length;
        logic              segment_unbacked;
        logic [LEN_W-1:0]  byte_count;
    } sgc_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] chunk_address;
        logic [LEN_W-1:0]  chunk_length;
        logic              to_segment;
        logic              skip_copy;
        logic              last_chunk;
        logic [LEN_W-1:0]  total_moved;
        logic              peek_ok;
    } sgc_chunk_t;

    // One entry of the segment memory
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  length;
        logic              unbacked;
    } sgc_seg_t;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } sgc_state_t;

endpackage

// ===== rtl/scatter_gather_chunker.sv =====
// Channel | Direction | Handshake                  | Beat
// cmd     | in        | cmd_valid / cmd_stall      | sgc_pkg::sgc_cmd_t
// chunk   | out       | chunk_valid / chunk_stall  | sgc_pkg::sgc_chunk_t
//
// A command is accepted in ST_IDLE and then carried out in ST_WORK; a transfer
// yields k chunks (k <= 16).
// The pace is set by the single segment memory: its registered read always
// presents the head entry, and one chunk is cut from it per cycle unless chunk stalls.
// Reset clears the control registers (state, list pointers, offset, counts, output valid); the memory is not swept.
// A stall on chunk holds the output register and pauses the walk.
`include "scatter_gather_chunker_assert.svh"

module scatter_gather_chunker #(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  sgc_pkg::sgc_cmd_t   cmd,
    output logic                chunk_valid,
    input  logic                chunk_stall,
    output sgc_pkg::sgc_chunk_t chunk
);

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    sgc_pkg::sgc_state_t state_reg, state_next;
    sgc_pkg::sgc_cmd_t   cmd_reg, cmd_next;
    logic [CNT_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic [sgc_pkg::LEN_W-1:0] off_reg, off_next;
    logic [sgc_pkg::LEN_W-1:0] moved_reg, moved_next;
    logic [sgc_pkg::RES_W-1:0] n_reg, n_next;
    logic                out_valid_reg, out_valid_next;
    sgc_pkg::sgc_chunk_t out_reg, out_next;

    // Segment memory and its registered read port
    sgc_pkg::sgc_seg_t seg_mem [MAX_SEGMENTS];
    sgc_pkg::sgc_seg_t entry_reg;
    sgc_pkg::sgc_seg_t wdata;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  raddr;

    // Datapath
    logic [sgc_pkg::LEN_W-1:0]  room;
    logic [sgc_pkg::LEN_W-1:0]  want;
    logic [sgc_pkg::LEN_W-1:0]  step_len;
    logic [sgc_pkg::LEN_W-1:0]  new_off;
    logic [sgc_pkg::LEN_W-1:0]  new_moved;
    logic [sgc_pkg::ADDR_W-1:0] base_eff;
    logic [sgc_pkg::ADDR_W-1:0] cur_addr;
    logic [CNT_W-1:0]           new_left;
    logic [CNT_W:0]             slot;
    logic                       seg_end;
    logic                       has_seg;
    logic                       skip;
    logic                       more;
    logic                       first_cont;
    logic                       dir_write;
    logic                       can_emit;

    assign cmd_stall   = (state_reg != sgc_pkg::ST_IDLE);
    assign chunk_valid = out_valid_reg;
    assign chunk       = out_reg;

    // Cut one step from the head segment; moved is zero for peek and consume
    always_comb
    begin
        room       = entry_reg.length - off_reg;
        want       = cmd_reg.byte_count - moved_reg;
        step_len   = (room < want) ? room : want;
        new_off    = off_reg + step_len;
        seg_end    = (new_off == entry_reg.length);
        has_seg    = (left_reg != '0);
        new_left   = left_reg - CNT_W'(seg_end);
        new_moved  = moved_reg + step_len;
        base_eff   = entry_reg.unbacked ? '0 : entry_reg.base;
        cur_addr   = base_eff + sgc_pkg::ADDR_W'(off_reg);
        skip       = entry_reg.unbacked || (step_len == '0);
        more       = (new_moved < cmd_reg.byte_count) && (new_left != '0)
                     && (n_reg != sgc_pkg::RES_W'(sgc_pkg::MAX_RESULTS - 1));
        first_cont = (moved_reg < cmd_reg.byte_count) && has_seg;
        slot       = {1'b0, head_reg} + {1'b0, left_reg};
        dir_write  = (cmd_reg.kind == sgc_pkg::KIND_WRITE);
        can_emit   = !out_valid_reg || !chunk_stall;
    end

    // Next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        head_next      = head_reg;
        left_next      = left_reg;
        off_next       = off_reg;
        moved_next     = moved_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && chunk_stall;
        out_next       = out_reg;
        we             = 1'b0;
        waddr          = slot[IDX_W-1:0];
        wdata.base     = cmd_reg.segment_base;
        wdata.length   = cmd_reg.segment_length;
        wdata.unbacked = cmd_reg.segment_unbacked;

        case (state_reg)
            sgc_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    moved_next = '0;
                    n_next     = '0;
                    state_next = sgc_pkg::ST_WORK;
                end
            end
            sgc_pkg::ST_WORK:
            begin
                case (cmd_reg.kind)
                    sgc_pkg::KIND_CLEAR:
                    begin
                        head_next  = '0;
                        left_next  = '0;
                        off_next   = '0;
                        state_next = sgc_pkg::ST_IDLE;
                    end
                    sgc_pkg::KIND_APPEND:
                    begin
                        if (slot < (CNT_W+1)'(MAX_SEGMENTS))
                        begin
                            we        = 1'b1;
                            left_next = left_reg + 1'b1;
                        end
                        state_next = sgc_pkg::ST_IDLE;
                    end
                    sgc_pkg::KIND_READ, sgc_pkg::KIND_WRITE:
                    begin
                        if (can_emit)
                        begin
                            out_valid_next = 1'b1;
                            if ((n_reg == '0) && !first_cont)
                            begin
                                // nothing to move: one empty closing beat
                                out_next.chunk_address = '0;
                                out_next.chunk_length  = '0;
                                out_next.to_segment    = dir_write;
                                out_next.skip_copy     = 1'b1;
                                out_next.last_chunk    = 1'b1;
                                out_next.total_moved   = '0;
                                out_next.peek_ok       = 1'b0;
                                state_next             = sgc_pkg::ST_IDLE;
                            end
                            else
                            begin
                                out_next.chunk_address = cur_addr;
                                out_next.chunk_length  = step_len;
                                out_next.to_segment    = dir_write;
                                out_next.skip_copy     = skip;
                                out_next.last_chunk    = !more;
                                out_next.total_moved   = more ? '0 : new_moved;
                                out_next.peek_ok       = 1'b0;
                                moved_next             = new_moved;
                                n_next                 = n_reg + 1'b1;
                                if (seg_end)
                                begin
                                    head_next = head_reg + 1'b1;
                                    left_next = new_left;
                                    off_next  = '0;
                                end
                                else
                                begin
                                    off_next = new_off;
                                end
                                if (!more)
                                begin
                                    state_next = sgc_pkg::ST_IDLE;
                                end
                            end
                        end
                    end
                    sgc_pkg::KIND_PEEK:
                    begin
                        if (can_emit)
                        begin
                            out_valid_next         = 1'b1;
                            out_next.chunk_address = has_seg ? cur_addr : '0;
                            out_next.chunk_length  = has_seg ? step_len : '0;
                            out_next.to_segment    = 1'b0;
                            out_next.skip_copy     = has_seg && skip;
                            out_next.last_chunk    = 1'b1;
                            out_next.total_moved   = '0;
                            out_next.peek_ok       = has_seg;
                            state_next             = sgc_pkg::ST_IDLE;
                        end
                    end
                    sgc_pkg::KIND_CONSUME:
                    begin
                        if (has_seg)
                        begin
                            if (seg_end)
                            begin
                                head_next = head_reg + 1'b1;
                                left_next = new_left;
                                off_next  = '0;
                            end
                            else
                            begin
                                off_next = new_off;
                            end
                        end
                        state_next = sgc_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        state_next = sgc_pkg::ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = sgc_pkg::ST_IDLE;
            end
        endcase
    end

    // Read address follows the next head so the head entry is always on hand
    assign raddr = (head_next < CNT_W'(MAX_SEGMENTS)) ? head_next[IDX_W-1:0] : '0;

    // Memory write and registered read with write forwarding
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            seg_mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            entry_reg <= wdata;
        end
        else
        begin
            entry_reg <= seg_mem[raddr];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sgc_pkg::ST_IDLE;
            head_reg      <= '0;
            left_reg      <= '0;
            off_reg       <= '0;
            moved_reg     <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            left_reg      <= left_next;
            off_reg       <= off_next;
            moved_reg     <= moved_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Checks
    `SGC_ASSERT_NOW(a_list_in_bounds, 1'b1,
        (slot <= (CNT_W+1)'(MAX_SEGMENTS)), "segment list runs past the memory")
    `SGC_ASSERT_NOW(a_offset_in_segment, (left_reg != '0),
        (off_reg <= entry_reg.length), "offset beyond current segment")
    `SGC_ASSERT_NOW(a_moved_le_request, (state_reg == sgc_pkg::ST_WORK),
        (moved_reg <= cmd_reg.byte_count), "moved more than requested")
    `SGC_ASSERT_NOW(a_peek_single_beat, (out_valid_reg && out_reg.peek_ok),
        out_reg.last_chunk, "peek beat without last mark")
    `SGC_ASSERT_NEXT(a_last_ends_work,
        (state_reg == sgc_pkg::ST_WORK && !out_valid_reg
         && (cmd_reg.kind == sgc_pkg::KIND_PEEK)),
        (state_reg == sgc_pkg::ST_IDLE), "peek did not finish with a free output")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS = 16;
    localparam logic [sgc_pkg::KIND_W-1:0] KIND_RSVD_6 = 3'd6;
    localparam logic [sgc_pkg::KIND_W-1:0] KIND_RSVD_7 = 3'd7;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 40;

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    sgc_pkg::sgc_cmd_t   cmd;
    logic                chunk_valid;
    logic                chunk_stall;
    sgc_pkg::sgc_chunk_t chunk;

    scatter_gather_chunker i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .chunk_valid (chunk_valid),
        .chunk_stall (chunk_stall),
        .chunk       (chunk)
    );

    // Shadow copy of the segment list
    logic [sgc_pkg::ADDR_W-1:0] seg_base_copy [SLOTS];
    logic [sgc_pkg::LEN_W-1:0]  seg_len_copy [SLOTS];
    logic                       seg_unbacked_copy [SLOTS];
    int                         head_slot;
    int                         segs_left;
    logic [sgc_pkg::LEN_W-1:0]  seg_offset;

    sgc_pkg::sgc_chunk_t pending_chunks [$];
    int                  mismatch_count;
    bit                  idle_on;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [sgc_pkg::ADDR_W-1:0] seg_address();
        logic [sgc_pkg::ADDR_W-1:0] b;
        b = seg_unbacked_copy[head_slot] ? '0 : seg_base_copy[head_slot];
        return b + sgc_pkg::ADDR_W'(seg_offset);
    endfunction

    function automatic void next_segment();
        head_slot++;
        segs_left--;
        seg_offset = '0;
    endfunction

    // Update the shadow list for one accepted beat and queue the chunks it yields
    task automatic cut_chunks(input sgc_pkg::sgc_cmd_t c);
        sgc_pkg::sgc_chunk_t       cut [sgc_pkg::MAX_RESULTS];
        sgc_pkg::sgc_chunk_t       r;
        logic [sgc_pkg::LEN_W-1:0] moved;
        logic [sgc_pkg::LEN_W-1:0] room;
        logic [sgc_pkg::LEN_W-1:0] want;
        logic [sgc_pkg::LEN_W-1:0] piece;
        int                        n;
        int                        i;
        moved = '0;
        n = 0;
        case (c.kind)
            sgc_pkg::KIND_CLEAR:
            begin
                head_slot = 0;
                segs_left = 0;
                seg_offset = '0;
            end
            sgc_pkg::KIND_APPEND:
            begin
                // full list: append dropped
                if (head_slot + segs_left < SLOTS)
                begin
                    seg_base_copy[head_slot + segs_left] = c.segment_base;
                    seg_len_copy[head_slot + segs_left] = c.segment_length;
                    seg_unbacked_copy[head_slot + segs_left] = c.segment_unbacked;
                    segs_left++;
                end
            end
            sgc_pkg::KIND_READ, sgc_pkg::KIND_WRITE:
            begin
                while (moved < c.byte_count && segs_left > 0 && n < sgc_pkg::MAX_RESULTS)
                begin
                    room = seg_len_copy[head_slot] - seg_offset;
                    want = c.byte_count - moved;
                    piece = (room < want) ? room : want;
                    r = '0;
                    r.chunk_address = seg_address();
                    r.chunk_length = piece;
                    r.to_segment = (c.kind == sgc_pkg::KIND_WRITE);
                    r.skip_copy = seg_unbacked_copy[head_slot] || (piece == '0);
                    cut[n] = r;
                    n++;
                    moved += piece;
                    seg_offset += piece;
                    if (seg_offset == seg_len_copy[head_slot])
                        next_segment();
                end
                if (n == 0)
                begin
                    // nothing to move: single empty chunk
                    r = '0;
                    r.to_segment = (c.kind == sgc_pkg::KIND_WRITE);
                    r.skip_copy = 1'b1;
                    r.last_chunk = 1'b1;
                    pending_chunks.push_back(r);
                end
                else
                begin
                    cut[n - 1].last_chunk = 1'b1;
                    cut[n - 1].total_moved = moved;
                    for (i = 0; i < n; i++)
                        pending_chunks.push_back(cut[i]);
                end
            end
            sgc_pkg::KIND_PEEK:
            begin
                r = '0;
                r.last_chunk = 1'b1;
                if (segs_left > 0)
                begin
                    room = seg_len_copy[head_slot] - seg_offset;
                    piece = (c.byte_count < room) ? c.byte_count : room;
                    r.chunk_address = seg_address();
                    r.chunk_length = piece;
                    r.skip_copy = seg_unbacked_copy[head_slot] || (piece == '0);
                    r.peek_ok = 1'b1;
                end
                pending_chunks.push_back(r);
            end
            sgc_pkg::KIND_CONSUME:
            begin
                // clamped to the segment remainder, ignored on an empty list
                if (segs_left > 0)
                begin
                    room = seg_len_copy[head_slot] - seg_offset;
                    seg_offset += (c.byte_count < room) ? c.byte_count : room;
                    if (seg_offset == seg_len_copy[head_slot])
                        next_segment();
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Drive one command beat, with an optional random gap in front of it
    task automatic send_cmd(input sgc_pkg::sgc_cmd_t c);
        bit taken;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cmd <= c;
        cmd_valid <= 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            if (!cmd_stall)
            begin
                cut_chunks(c);
                taken = 1'b1;
            end
            @(posedge clk);
        end
    endtask

    // Hold the command side until every queued chunk has come back
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_chunks.size() != 0);
    endtask

    function automatic sgc_pkg::sgc_cmd_t mk_cmd(input logic [sgc_pkg::KIND_W-1:0] kind,
                                                 input logic [sgc_pkg::ADDR_W-1:0] base,
                                                 input logic [sgc_pkg::LEN_W-1:0] seg_len,
                                                 input logic unbacked,
                                                 input logic [sgc_pkg::LEN_W-1:0] bytes);
        sgc_pkg::sgc_cmd_t c;
        c.kind = kind;
        c.segment_base = base;
        c.segment_length = seg_len;
        c.segment_unbacked = unbacked;
        c.byte_count = bytes;
        return c;
    endfunction

    // Mostly small sizes so transfers span several segments
    function automatic logic [sgc_pkg::LEN_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return sgc_pkg::LEN_W'($urandom);
            2: return '1;
            default: return sgc_pkg::LEN_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic sgc_pkg::sgc_cmd_t rand_cmd(input logic [sgc_pkg::KIND_W-1:0] kind);
        sgc_pkg::sgc_cmd_t c;
        c.kind = kind;
        c.segment_base = $urandom;
        c.segment_length = pick_size();
        c.segment_unbacked = ($urandom_range(0, 3) == 0);
        c.byte_count = pick_size();
        return c;
    endfunction

    // One list build followed by walk operations, with some noise
    task automatic run_walk_sequence(output int sent);
        int n_seg;
        int n_ops;
        int i;
        sent = 0;
        if ($urandom_range(0, 4) != 0)
        begin
            send_cmd(rand_cmd(sgc_pkg::KIND_CLEAR));
            sent++;
        end
        n_seg = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 6);
        for (i = 0; i < n_seg; i++)
        begin
            send_cmd(rand_cmd(sgc_pkg::KIND_APPEND));
            sent++;
        end
        n_ops = $urandom_range(2, 10);
        for (i = 0; i < n_ops; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_cmd(rand_cmd(sgc_pkg::KIND_READ));
                3, 4, 5: send_cmd(rand_cmd(sgc_pkg::KIND_WRITE));
                6:       send_cmd(rand_cmd(sgc_pkg::KIND_PEEK));
                7, 8:    send_cmd(rand_cmd(sgc_pkg::KIND_CONSUME));
                default: send_cmd(rand_cmd(sgc_pkg::KIND_APPEND));
            endcase
            sent++;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            send_cmd(rand_cmd($urandom_range(0, 1) ? KIND_RSVD_6 : KIND_RSVD_7));
            sent++;
        end
    endtask

    // Transfers, peek, consume and the reserved kinds against a list that was never filled
    task automatic test_empty_list();
        send_cmd(mk_cmd(sgc_pkg::KIND_READ, '0, '0, 1'b0, 24'd100));
        send_cmd(mk_cmd(sgc_pkg::KIND_WRITE, '1, '1, 1'b1, '0));
        send_cmd(mk_cmd(sgc_pkg::KIND_PEEK, '0, '0, 1'b0, 24'd5));
        send_cmd(mk_cmd(sgc_pkg::KIND_CONSUME, '0, '0, 1'b0, 24'd5));
        send_cmd(rand_cmd(KIND_RSVD_6));
        send_cmd(rand_cmd(KIND_RSVD_7));
    endtask

    // Address wrap, zero-length and unbacked segments, clamping, exhaustion
    task automatic test_segment_walk();
        send_cmd(mk_cmd(sgc_pkg::KIND_CLEAR, '0, '0, 1'b0, '0));
        send_cmd(mk_cmd(sgc_pkg::KIND_APPEND, 32'hFFFF_FFF0, 24'h20, 1'b0, '0));
        send_cmd(mk_cmd(sgc_pkg::KIND_APPEND, 32'h0000_1234, '0, 1'b0, '0));
        send_cmd(mk_cmd(sgc_pkg::KIND_APPEND, 32'hDEAD_BEEF, '1, 1'b1, '0));
        send_cmd(mk_cmd(sgc_pkg::KIND_APPEND, '0, 24'd1, 1'b0, '0));
        send_cmd(mk_cmd(sgc_pkg::KIND_PEEK, '0, '0, 1'b0, '0));
        send_cmd(mk_cmd(sgc_pkg::KIND_PEEK, '0, '0, 1'b0, '1));
        send_cmd(mk_cmd(sgc_pkg::KIND_READ, '0, '0, 1'b0, 24'h10));
        send_cmd(mk_cmd(sgc_pkg::KIND_WRITE, '0, '0, 1'b0, '1));
        send_cmd(mk_cmd(sgc_pkg::KIND_CONSUME, '0, '0, 1'b0, '1));
        send_cmd(mk_cmd(sgc_pkg::KIND_PEEK, '0, '0, 1'b0, 24'd7));
        send_cmd(mk_cmd(sgc_pkg::KIND_READ, '0, '0, 1'b0, '1));
        send_cmd(mk_cmd(sgc_pkg::KIND_PEEK, '0, '0, 1'b0, 24'd1));
    endtask

    // Random list walks with idling switched on and off in stretches
    task automatic test_random_walks(input int quota);
        int total;
        int sent;
        total = 0;
        idle_on = 1'b1;
        while (total < quota)
        begin
            if ($urandom_range(0, 5) == 0)
                idle_on = !idle_on;
            run_walk_sequence(sent);
            total += sent;
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_final_burst(input int quota);
        int total;
        int sent;
        total = 0;
        idle_on = 1'b0;
        while (total < quota)
        begin
            run_walk_sequence(sent);
            total += sent;
        end
    endtask

    function automatic bit same_chunk(input sgc_pkg::sgc_chunk_t a,
                                      input sgc_pkg::sgc_chunk_t b);
        return a.chunk_address === b.chunk_address && a.chunk_length === b.chunk_length
            && a.to_segment === b.to_segment && a.skip_copy === b.skip_copy
            && a.last_chunk === b.last_chunk && a.total_moved === b.total_moved
            && a.peek_ok === b.peek_ok;
    endfunction

    function automatic string show_chunk(input sgc_pkg::sgc_chunk_t c);
        return $sformatf("addr=%h len=%h to=%b skip=%b last=%b total=%h ok=%b",
                         c.chunk_address, c.chunk_length, c.to_segment, c.skip_copy,
                         c.last_chunk, c.total_moved, c.peek_ok);
    endfunction

    // Chunk side stall bursts
    initial
    begin : chunk_stall_gen
        int hold;
        hold = 0;
        chunk_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                chunk_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(0, 4);
                chunk_stall <= 1'b1;
            end
            else
            begin
                chunk_stall <= 1'b0;
            end
        end
    end

    // Compare every accepted chunk beat with the oldest queued one
    initial
    begin : chunk_checker
        sgc_pkg::sgc_chunk_t got;
        sgc_pkg::sgc_chunk_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && chunk_valid && !chunk_stall)
            begin
                got = chunk;
                if (pending_chunks.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t unexpected chunk: %s", $realtime, show_chunk(got));
                end
                else
                begin
                    want = pending_chunks.pop_front();
                    if (!same_chunk(want, got))
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("%0t chunk mismatch", $realtime);
                            $display("  expected %s", show_chunk(want));
                            $display("  actual   %s", show_chunk(got));
                        end
                    end
                end
            end
        end
    end

    // Test sequence
    initial
    begin : run
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        idle_on = 1'b0;
        mismatch_count = 0;
        head_slot = 0;
        segs_left = 0;
        seg_offset = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_segment_walk();
        wait_drained();
        test_random_walks(240);
        test_final_burst(50);

        cmd_valid <= 1'b0;
        while (pending_chunks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_chunks.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sgc_pkg.sv
rtl/scatter_gather_chunker.sv
tb/tb.sv
